/* design/lacf_pkg.sv */
`default_nettype none
package lacf_pkg;

   localparam int MAX_GAP  = 16;
   localparam int MAX_LEN  = 256;
   localparam int WIN_ROWS = MAX_GAP + 1;
   localparam int COL_W    = $clog2(MAX_LEN);
   localparam int ROW_W    = 9;
   localparam int SLOT_W   = $clog2(WIN_ROWS);
   localparam int CNT_W    = $clog2(MAX_GAP + 1);
   localparam int SCORE_W  = 24;
   localparam int ORG_W    = 6;
   localparam int COEF_W   = 16;
   localparam int COUNT_W  = 9;
   localparam int COST_W   = COEF_W + 1 + $clog2(MAX_GAP + 1);
   localparam int BEST_W   = ((SCORE_W > COST_W) ? SCORE_W : COST_W) + 2;
   localparam int SUM_W    = BEST_W + 2;
   localparam int TABLE_N  = 25;
   localparam int BASE_TOP = 4;

   localparam logic [SCORE_W-1:0] SCORE_TOP = {SCORE_W{1'b1}};
   localparam logic [ORG_W-1:0]   NO_ORIGIN = ORG_W'(MAX_GAP + 1);
   localparam logic [ORG_W-1:0]   ORG_DIAG  = '0;

   localparam logic KIND_LOAD = 1'b0;
   localparam logic KIND_CELL = 1'b1;

   typedef enum logic [2:0] {
      CSR_ROW_COUNT    = 3'd0,
      CSR_COLUMN_COUNT = 3'd1,
      CSR_GAP_OPEN     = 3'd2,
      CSR_GAP_EXTEND   = 3'd3,
      CSR_PAIR_BONUS   = 3'd4
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOAD,
      ST_CHAIN,
      ST_FINAL
   } state_type;

   // running gap cost and the two running bests that walk the cell chain
   typedef struct packed {
      logic signed [COST_W-1:0] cost;
      logic [ORG_W-1:0]         step;
      logic signed [BEST_W-1:0] row_val;
      logic [ORG_W-1:0]         row_org;
      logic signed [BEST_W-1:0] col_val;
      logic [ORG_W-1:0]         col_org;
   } tok_type;

endpackage
`default_nettype wire

/* design/local_alignment_cell_fill.sv */
// Local-alignment matrix fill, one cell per request in row-major order.
// req channel: tuser selects the kind; a load request writes one entry of
// the 5x5 substitution table and gives no result; a cell request gives one
// result on rsp (score and origin in tdata, tlast on the final cell).
// csr port: write enable, register index, data; write only while idle.
// A load request is taken while idle and does not hold off the next one.
// After a cell request is accepted, req_tready stays low until its result
// is stored in the output register. The cell passes through a banked
// row-memory read, a load of the gap-cell chain, and the chain itself, in
// which the running best moves through one of its 16 cells per cycle.
// The 17 row banks (one per row of the gap window) are read in parallel at
// one column; the column-gap candidates come from a 16-entry shift window.
// Reset: positions return to row 0, column 0, counts to 1, gap terms to 0.
// Score memories and the table are not cleared; they are valid once written.
// Stall: a finished result waits in the output register; a further request
// is still taken and worked on, and holds in its last step until the
// output register is free.
`default_nettype none
module local_alignment_cell_fill import lacf_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [4:0] table_index, [20:5] table_value, [23:21] x_base, [26:24] y_base,
   // [27] x_paired, [28] y_paired
   input  logic [31:0] req_tdata,
   // [0] kind
   input  logic [0:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [23:0] cell_score, [29:24] came_from
   output logic [31:0] rsp_tdata,
   output logic        rsp_tlast,
   input  logic        csr_wr_en,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_wr_data
);

   // configuration
   logic [COUNT_W-1:0]       row_count_ff;
   logic [COUNT_W-1:0]       column_count_ff;
   logic signed [COEF_W-1:0] gap_open_ff;
   logic signed [COEF_W-1:0] gap_extend_ff;
   logic signed [COEF_W-1:0] pair_bonus_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         row_count_ff    <= COUNT_W'(1);
         column_count_ff <= COUNT_W'(1);
         gap_open_ff     <= '0;
         gap_extend_ff   <= '0;
         pair_bonus_ff   <= '0;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_ROW_COUNT:    row_count_ff    <= csr_wr_data[COUNT_W-1:0];
            CSR_COLUMN_COUNT: column_count_ff <= csr_wr_data[COUNT_W-1:0];
            CSR_GAP_OPEN:     gap_open_ff     <= csr_wr_data;
            CSR_GAP_EXTEND:   gap_extend_ff   <= csr_wr_data;
            CSR_PAIR_BONUS:   pair_bonus_ff   <= csr_wr_data;
            default: ;
         endcase
      end
   end

   // request fields
   logic [4:0]         f_index;
   logic signed [15:0] f_value;
   logic [2:0]         f_xb;
   logic [2:0]         f_yb;
   logic               f_xp;
   logic               f_yp;

   assign f_index = req_tdata[4:0];
   assign f_value = req_tdata[20:5];
   assign f_xb    = req_tdata[23:21];
   assign f_yb    = req_tdata[26:24];
   assign f_xp    = req_tdata[27];
   assign f_yp    = req_tdata[28];

   state_type state_ff, state_in;
   logic      req_accept, cell_accept, load_go, final_fire, out_free;
   logic [CNT_W-1:0] cnt_ff;
   logic      rsp_valid_ff;

   assign req_accept  = req_tvalid && req_tready;
   assign cell_accept = req_accept && (req_tuser[0] == KIND_CELL);
   assign out_free    = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:  if (cell_accept) state_in = ST_LOAD;
         ST_LOAD:  state_in = ST_CHAIN;
         ST_CHAIN: if (cnt_ff == CNT_W'(MAX_GAP - 1)) state_in = ST_FINAL;
         ST_FINAL: if (out_free) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_tready = (state_ff == ST_IDLE);
      load_go    = (state_ff == ST_LOAD);
      final_fire = (state_ff == ST_FINAL) && out_free;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_CHAIN) cnt_ff <= cnt_ff + CNT_W'(1);
         else cnt_ff <= '0;
      end
   end

   // substitution table
   logic signed [COEF_W-1:0] score_table_ff [TABLE_N];

   always_ff @(posedge clock) begin
      if (req_accept && (req_tuser[0] == KIND_LOAD) && (f_index < 5'(TABLE_N))) begin
         score_table_ff[f_index] <= f_value;
      end
   end

   // matrix position
   logic [ROW_W-1:0]   row_pos_ff;
   logic [COL_W-1:0]   col_pos_ff;
   logic [SLOT_W-1:0]  row_slot_ff;
   logic [COUNT_W-1:0] nrows, ncols, row_next, col_next;
   logic               wrap_col, wrap_row;

   always_comb begin
      nrows = (row_count_ff == '0) ? COUNT_W'(1) : row_count_ff;
      if (column_count_ff == '0) ncols = COUNT_W'(1);
      else if (column_count_ff > COUNT_W'(MAX_LEN)) ncols = COUNT_W'(MAX_LEN);
      else ncols = column_count_ff;
      col_next = COUNT_W'(col_pos_ff) + COUNT_W'(1);
      row_next = COUNT_W'(row_pos_ff) + COUNT_W'(1);
      wrap_col = (col_next >= ncols);
      wrap_row = (row_next >= nrows);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_pos_ff  <= '0;
         col_pos_ff  <= '0;
         row_slot_ff <= '0;
      end else if (cell_accept) begin
         if (!wrap_col) begin
            col_pos_ff <= col_next[COL_W-1:0];
         end else begin
            col_pos_ff <= '0;
            if (wrap_row) begin
               row_pos_ff  <= '0;
               row_slot_ff <= '0;
            end else begin
               row_pos_ff  <= row_next[ROW_W-1:0];
               row_slot_ff <= (row_slot_ff == SLOT_W'(WIN_ROWS - 1)) ? '0
                              : row_slot_ff + SLOT_W'(1);
            end
         end
      end
   end

   // cell request held for the whole computation
   logic [ROW_W-1:0]  item_row_ff;
   logic [COL_W-1:0]  item_col_ff;
   logic [SLOT_W-1:0] item_slot_ff;
   logic              item_last_ff;
   logic [2:0]        item_xb_ff, item_yb_ff;
   logic              item_xp_ff, item_yp_ff;

   always_ff @(posedge clock) begin
      if (cell_accept) begin
         item_row_ff  <= row_pos_ff;
         item_col_ff  <= col_pos_ff;
         item_slot_ff <= row_slot_ff;
         item_last_ff <= wrap_col && wrap_row;
         item_xb_ff   <= f_xb;
         item_yb_ff   <= f_yb;
         item_xp_ff   <= f_xp;
         item_yp_ff   <= f_yp;
      end
   end

   // newest score waits here until the next cell has read its predecessors
   logic               pend_valid_ff;
   logic [SLOT_W-1:0]  pend_slot_ff;
   logic [COL_W-1:0]   pend_col_ff;
   logic [SCORE_W-1:0] pend_val_ff;
   logic [SCORE_W-1:0] fin_score;
   logic [ORG_W-1:0]   fin_org;

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
      end else if (final_fire) begin
         pend_valid_ff <= 1'b1;
      end else if (cell_accept) begin
         pend_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (final_fire) begin
         pend_slot_ff <= item_slot_ff;
         pend_col_ff  <= item_col_ff;
         pend_val_ff  <= fin_score;
      end
   end

   // row banks, one per row of the gap window
   logic [SCORE_W-1:0] bank_q [WIN_ROWS];

   for (genvar b = 0; b < WIN_ROWS; b++) begin : g_bank
      lacf_bank u_bank (
         .clock   (clock),
         .wr_en   (cell_accept && pend_valid_ff && (pend_slot_ff == SLOT_W'(b))),
         .wr_addr (pend_col_ff),
         .wr_data (pend_val_ff),
         .rd_en   (cell_accept),
         .rd_addr (col_pos_ff - COL_W'(1)),
         .rd_data (bank_q[b])
      );
   end

   // score of row i-1-k at column j-1, for k = 0 (diagonal) up to MAX_GAP
   logic [SCORE_W-1:0] up_val [WIN_ROWS];

   always_comb begin
      logic [SLOT_W:0] sel;
      for (int k = 0; k < WIN_ROWS; k++) begin
         sel = (SLOT_W+1)'(item_slot_ff) + (SLOT_W+1)'(WIN_ROWS - 1 - k);
         if (sel >= (SLOT_W+1)'(WIN_ROWS)) sel = sel - (SLOT_W+1)'(WIN_ROWS);
         up_val[k] = bank_q[sel[SLOT_W-1:0]];
      end
   end

   // row i-1 to the left of column j-1, shifted in one column per cell
   logic [SCORE_W-1:0] win_ff [MAX_GAP];

   always_ff @(posedge clock) begin
      if (load_go) begin
         win_ff[0] <= up_val[0];
         for (int n = 1; n < MAX_GAP; n++) win_ff[n] <= win_ff[n-1];
      end
   end

   logic    edge_ok;
   tok_type head_ff;
   tok_type tok [MAX_GAP];

   assign edge_ok = (item_row_ff != '0) && (item_col_ff != '0);

   always_ff @(posedge clock) begin
      if (load_go) begin
         head_ff.cost    <= COST_W'(gap_open_ff);
         head_ff.step    <= '0;
         head_ff.col_val <= '0;
         head_ff.col_org <= NO_ORIGIN;
         if (edge_ok && (up_val[0] != '0)) begin
            head_ff.row_val <= $signed({{(BEST_W-SCORE_W){1'b0}}, up_val[0]});
            head_ff.row_org <= ORG_DIAG;
         end else begin
            head_ff.row_val <= '0;
            head_ff.row_org <= NO_ORIGIN;
         end
      end
   end

   for (genvar n = 0; n < MAX_GAP; n++) begin : g_cell
      lacf_cell u_cell (
         .clock      (clock),
         .load       (load_go),
         .row_cand   (up_val[n+1]),
         .col_cand   (win_ff[n]),
         .row_ok     (edge_ok && (ROW_W'(n + 1) < item_row_ff)),
         .col_ok     (edge_ok && (COL_W'(n + 1) < item_col_ff)),
         .gap_extend (gap_extend_ff),
         .prev_tok   ((n == 0) ? head_ff : tok[(n == 0) ? 0 : n - 1]),
         .this_tok   (tok[n])
      );
   end

   // combine the row and column bests, add the pair score, clamp
   always_comb begin
      logic signed [BEST_W-1:0] best_val;
      logic [ORG_W-1:0]         best_org;
      logic [2:0]               xb, yb;
      logic [4:0]               pidx;
      logic signed [SUM_W-1:0]  pair;
      logic signed [SUM_W-1:0]  sum;
      if (tok[MAX_GAP-1].col_val > tok[MAX_GAP-1].row_val) begin
         best_val = tok[MAX_GAP-1].col_val;
         best_org = tok[MAX_GAP-1].col_org;
      end else begin
         best_val = tok[MAX_GAP-1].row_val;
         best_org = tok[MAX_GAP-1].row_org;
      end
      xb   = (item_xb_ff > 3'(BASE_TOP)) ? 3'(BASE_TOP) : item_xb_ff;
      yb   = (item_yb_ff > 3'(BASE_TOP)) ? 3'(BASE_TOP) : item_yb_ff;
      pidx = {2'b00, xb} * 5'd5 + {2'b00, yb};
      pair = SUM_W'(score_table_ff[pidx]);
      if (item_xp_ff) pair = pair + SUM_W'(pair_bonus_ff);
      sum = SUM_W'(best_val) + pair;
      if (item_xp_ff != item_yp_ff) begin
         fin_score = '0;
         fin_org   = NO_ORIGIN;
      end else if (sum < 0) begin
         fin_score = '0;
         fin_org   = NO_ORIGIN;
      end else if (sum > SUM_W'(SCORE_TOP)) begin
         fin_score = SCORE_TOP;
         fin_org   = best_org;
      end else begin
         fin_score = sum[SCORE_W-1:0];
         fin_org   = best_org;
      end
   end

   // output register
   logic [SCORE_W-1:0] rsp_score_ff;
   logic [ORG_W-1:0]   rsp_org_ff;
   logic               rsp_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (final_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (final_fire) begin
         rsp_score_ff <= fin_score;
         rsp_org_ff   <= fin_org;
         rsp_last_ff  <= item_last_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_org_ff, rsp_score_ff};
   assign rsp_tlast  = rsp_last_ff;

   // a cell request blocks further requests until its result is stored
   a_cell_busy: assert property (@(posedge clock) disable iff (reset)
      cell_accept |=> !req_tready)
      else $error("request taken while a cell is in progress");

   // a stored result leaves its score pending for the next cell
   a_pend_set: assert property (@(posedge clock) disable iff (reset)
      final_fire |=> (pend_valid_ff && rsp_valid_ff && (pend_val_ff == rsp_score_ff)))
      else $error("pending score does not match the result");

   // the pending score is written exactly when the next cell is taken
   a_pend_commit: assert property (@(posedge clock) disable iff (reset)
      (cell_accept && pend_valid_ff) |=> !pend_valid_ff)
      else $error("pending score not committed");

endmodule
`default_nettype wire

/* design/lacf_bank.sv */
`default_nettype none
module lacf_bank import lacf_pkg::*; (
   input  logic               clock,
   input  logic               wr_en,
   input  logic [COL_W-1:0]   wr_addr,
   input  logic [SCORE_W-1:0] wr_data,
   input  logic               rd_en,
   input  logic [COL_W-1:0]   rd_addr,
   output logic [SCORE_W-1:0] rd_data
);

   logic [SCORE_W-1:0] mem [MAX_LEN];
   logic [SCORE_W-1:0] rd_ff;

   // read-first: a read and a write at one address return the old score
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_ff;

endmodule
`default_nettype wire

/* design/lacf_cell.sv */
`default_nettype none
module lacf_cell import lacf_pkg::*; (
   input  logic                     clock,
   input  logic                     load,
   input  logic [SCORE_W-1:0]       row_cand,
   input  logic [SCORE_W-1:0]       col_cand,
   input  logic                     row_ok,
   input  logic                     col_ok,
   input  logic signed [COEF_W-1:0] gap_extend,
   input  tok_type                  prev_tok,
   output tok_type                  this_tok
);

   logic [SCORE_W-1:0]       row_cand_ff;
   logic [SCORE_W-1:0]       col_cand_ff;
   logic                     row_ok_ff;
   logic                     col_ok_ff;
   tok_type                  tok_ff;
   tok_type                  tok_in;
   logic signed [COST_W-1:0] cost;
   logic signed [BEST_W-1:0] row_sum;
   logic signed [BEST_W-1:0] col_sum;
   logic [ORG_W-1:0]         step;

   always_comb begin
      step    = prev_tok.step + ORG_W'(1);
      cost    = prev_tok.cost + COST_W'(gap_extend);
      row_sum = BEST_W'($signed({1'b0, row_cand_ff})) + BEST_W'(cost);
      col_sum = BEST_W'($signed({1'b0, col_cand_ff})) + BEST_W'(cost);
      tok_in      = prev_tok;
      tok_in.step = step;
      tok_in.cost = cost;
      if (row_ok_ff && (row_sum > prev_tok.row_val)) begin
         tok_in.row_val = row_sum;
         tok_in.row_org = step;
      end
      if (col_ok_ff && (col_sum > prev_tok.col_val)) begin
         tok_in.col_val = col_sum;
         tok_in.col_org = ORG_W'(0) - step;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         row_cand_ff <= row_cand;
         col_cand_ff <= col_cand;
         row_ok_ff   <= row_ok;
         col_ok_ff   <= col_ok;
      end
      tok_ff <= tok_in;
   end

   assign this_tok = tok_ff;

endmodule
`default_nettype wire

/* verif/tb_local_alignment_cell_fill.sv */
`timescale 1ns / 1ps
module tb_local_alignment_cell_fill;
   import lacf_pkg::*;

   typedef struct {
      logic [23:0] score;
      logic [5:0]  origin;
      logic        last;
   } cell_result_t;

   typedef struct {
      logic        kind;
      logic [4:0]  idx;
      logic [15:0] val;
      logic [2:0]  xb;
      logic [2:0]  yb;
      logic        xp;
      logic        yp;
      bit          typed;
      logic [23:0] score;
      logic [5:0]  origin;
   } stim_row_t;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [31:0] req_tdata;
   logic [0:0]  req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [31:0] rsp_tdata;
   logic        rsp_tlast;
   logic        csr_wr_en;
   logic [2:0]  csr_index;
   logic [15:0] csr_wr_data;

   local_alignment_cell_fill i_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tlast(rsp_tlast),
      .csr_wr_en(csr_wr_en), .csr_index(csr_index), .csr_wr_data(csr_wr_data)
   );

   // predictor state
   logic [23:0]        score_win [WIN_ROWS][MAX_LEN];
   logic signed [15:0] subst_tbl [TABLE_N];
   bit                 held_valid;
   int                 held_row, held_col;
   logic [23:0]        held_val;
   int                 row_pos, col_pos;
   logic [8:0]         row_cnt, col_cnt;
   logic signed [15:0] gap_open, gap_ext, pair_bonus;

   cell_result_t pending_cells[$];
   int  mismatches = 0;
   int  cells_seen = 0;
   int  requests_sent = 0;
   int  saturated = 0;
   int  matrices = 0;
   int  idle_mode = 0;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #20ms;
      $display("Mismatches found");
      $finish;
   end

   function automatic void fill_cell(logic [2:0] xb_in, logic [2:0] yb_in, logic xp,
                                     logic yp);
      longint       best, cand, pr;
      int           org, i, j, k, nr, nc, xb, yb;
      bit           lst;
      cell_result_t e;
      nr = (row_cnt == 0) ? 1 : row_cnt;
      nc = (col_cnt == 0) ? 1 : col_cnt;
      if (nc > MAX_LEN) nc = MAX_LEN;
      i = row_pos;
      j = col_pos % MAX_LEN;
      best = 0;
      org = MAX_GAP + 1;
      lst = 0;
      if (i > 0 && j > 0) begin
         cand = score_win[(i-1) % WIN_ROWS][j-1];
         if (cand > best) begin best = cand; org = 0; end
         for (k = 1; k <= MAX_GAP && k <= i - 1; k++) begin
            cand = longint'(score_win[(i-1-k) % WIN_ROWS][j-1]) + longint'(gap_open)
                   + k * longint'(gap_ext);
            if (cand > best) begin best = cand; org = k; end
         end
         for (k = 1; k <= MAX_GAP && k <= j - 1; k++) begin
            cand = longint'(score_win[(i-1) % WIN_ROWS][j-1-k]) + longint'(gap_open)
                   + k * longint'(gap_ext);
            if (cand > best) begin best = cand; org = -k; end
         end
      end
      // the previous cell lands in the window only after this one has read
      if (held_valid) score_win[held_row % WIN_ROWS][held_col] = held_val;
      xb = (xb_in > BASE_TOP) ? BASE_TOP : xb_in;
      yb = (yb_in > BASE_TOP) ? BASE_TOP : yb_in;
      pr = subst_tbl[xb * 5 + yb];
      if (xp != yp) begin
         best = 0; org = MAX_GAP + 1;
      end else begin
         if (xp) pr += longint'(pair_bonus);
         best += pr;
         if (best < 0) begin best = 0; org = MAX_GAP + 1; end
         if (best > longint'(SCORE_TOP)) best = SCORE_TOP;
      end
      held_valid = 1; held_row = i; held_col = j; held_val = best[23:0];
      col_pos = j + 1;
      if (col_pos >= nc) begin
         col_pos = 0;
         row_pos = i + 1;
         if (row_pos >= nr) begin row_pos = 0; lst = 1; end
      end
      e.score = best[23:0];
      e.origin = 6'(org);
      e.last = lst;
      pending_cells.push_back(e);
   endfunction

   task automatic send_req(logic kind, logic [4:0] idx, logic [15:0] val, logic [2:0] xb,
                           logic [2:0] yb, logic xp, logic yp);
      @(negedge clock);
      while ((idle_mode == 1 && $urandom_range(0, 99) < 71) ||
             (idle_mode == 3 && $urandom_range(0, 99) < 6)) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= kind;
      req_tdata <= {3'b000, yp, xp, yb, xb, val, idx};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      requests_sent++;
      if (kind == KIND_LOAD) begin
         if (idx < TABLE_N) subst_tbl[idx] = val;
      end else begin
         fill_cell(xb, yb, xp, yp);
      end
   endtask

   task automatic drain();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_cells.size() != 0) @(posedge clock);
      // a trailing load may still be in flight
      repeat (25) @(posedge clock);
   endtask

   task automatic write_csr(csr_index_type r, logic [15:0] d);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= r;
      csr_wr_data <= d;
      case (r)
         CSR_ROW_COUNT:    row_cnt = d[8:0];
         CSR_COLUMN_COUNT: col_cnt = d[8:0];
         CSR_GAP_OPEN:     gap_open = d;
         CSR_GAP_EXTEND:   gap_ext = d;
         CSR_PAIR_BONUS:   pair_bonus = d;
         default: ;
      endcase
   endtask

   function automatic logic [15:0] rand_coef();
      if ($urandom_range(0, 1)) return 16'($urandom_range(0, 1000)) - 16'd700;
      return 16'($urandom);
   endfunction

   function automatic logic [15:0] rand_entry();
      if ($urandom_range(0, 1)) return 16'($urandom_range(0, 2047)) - 16'd900;
      return 16'($urandom);
   endfunction

   // receiver
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_tready <= !((idle_mode == 2 && $urandom_range(0, 99) < 71) ||
                         (idle_mode == 3 && $urandom_range(0, 99) < 6));
      end
   end

   always @(posedge clock) begin
      cell_result_t e;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_cells.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result score=%h origin=%h last=%b",
                        rsp_tdata[23:0], rsp_tdata[29:24], rsp_tlast);
         end else begin
            e = pending_cells.pop_front();
            cells_seen++;
            if (e.score == SCORE_TOP) saturated++;
            if (e.last) matrices++;
            if (rsp_tdata[23:0] !== e.score || rsp_tdata[29:24] !== e.origin ||
                rsp_tlast !== e.last) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("cell %0d: expected score=%h origin=%h last=%b, got %h %h %b",
                           cells_seen, e.score, e.origin, e.last,
                           rsp_tdata[23:0], rsp_tdata[29:24], rsp_tlast);
            end
         end
      end
   end

   stim_row_t directed [] = '{
      '{KIND_LOAD, 5'd0,  16'h7FFF, 3'd0, 3'd0, 0, 0, 0, 24'd0,     6'd0},
      '{KIND_CELL, 5'd0,  16'h0000, 3'd0, 3'd0, 0, 0, 1, 24'h007FFF, NO_ORIGIN},
      '{KIND_LOAD, 5'd0,  16'h8000, 3'd0, 3'd0, 0, 0, 0, 24'd0,     6'd0},
      '{KIND_CELL, 5'd0,  16'h0000, 3'd0, 3'd0, 1, 1, 1, 24'd0,     NO_ORIGIN},
      '{KIND_LOAD, 5'd31, 16'h1234, 3'd0, 3'd0, 0, 0, 0, 24'd0,     6'd0},
      '{KIND_CELL, 5'd0,  16'h0000, 3'd7, 3'd7, 0, 0, 0, 24'd0,     6'd0},
      '{KIND_CELL, 5'd0,  16'h0000, 3'd5, 3'd2, 1, 1, 0, 24'd0,     6'd0},
      '{KIND_CELL, 5'd0,  16'h0000, 3'd1, 3'd3, 1, 0, 1, 24'd0,     NO_ORIGIN},
      '{KIND_CELL, 5'd0,  16'h0000, 3'd4, 3'd6, 0, 1, 1, 24'd0,     NO_ORIGIN},
      '{KIND_LOAD, 5'd24, 16'h0000, 3'd0, 3'd0, 0, 0, 0, 24'd0,     6'd0},
      '{KIND_CELL, 5'd0,  16'h0000, 3'd4, 3'd4, 0, 0, 1, 24'd0,     NO_ORIGIN},
      '{KIND_LOAD, 5'd12, 16'h0100, 3'd0, 3'd0, 0, 0, 0, 24'd0,     6'd0},
      '{KIND_CELL, 5'd0,  16'h0000, 3'd2, 3'd2, 0, 0, 1, 24'h000100, NO_ORIGIN}
   };

   // phase presets: rows, columns, gap open, gap extend, pair bonus
   logic [15:0] presets [4][5] = '{
      '{16'd20,  16'd20,  16'h7FFF, 16'h7FFF, 16'h7FFF},
      '{16'd18,  16'd19,  16'h8000, 16'h8000, 16'h8000},
      '{16'd0,   16'd300, 16'hFF00, 16'h0040, 16'h0200},
      '{16'd256, 16'd2,   16'hFE00, 16'hFFC0, 16'h0100}
   };

   initial begin
      int nr, nc, n, p, budget;
      logic [15:0] cfg [5];
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = KIND_LOAD;
      csr_wr_en = 1'b0;
      csr_index = CSR_ROW_COUNT;
      csr_wr_data = '0;
      held_valid = 0;
      row_pos = 0; col_pos = 0;
      row_cnt = 1; col_cnt = 1;
      gap_open = 0; gap_ext = 0; pair_bonus = 0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // fill the whole table before any cell reads it
      for (int t = 0; t < TABLE_N; t++)
         send_req(KIND_LOAD, 5'(t), rand_entry(), 3'd0, 3'd0, 1'b0, 1'b0);
      foreach (directed[r]) begin
         send_req(directed[r].kind, directed[r].idx, directed[r].val, directed[r].xb,
                  directed[r].yb, directed[r].xp, directed[r].yp);
         if (directed[r].typed) begin
            pending_cells[$].score = directed[r].score;
            pending_cells[$].origin = directed[r].origin;
            pending_cells[$].last = 1'b1;
         end
      end

      p = 0;
      while (requests_sent < 2000) begin
         drain();
         idle_mode = p % 4;
         if (p < 4) begin
            for (int r = 0; r < 5; r++) cfg[r] = presets[p][r];
         end else begin
            cfg[0] = 16'($urandom_range(1, 20));
            cfg[1] = 16'($urandom_range(1, 24));
            cfg[2] = rand_coef();
            cfg[3] = rand_coef();
            cfg[4] = rand_coef();
            if ($urandom_range(0, 9) == 0) cfg[0] = 16'($urandom) & 16'hFE00;
         end
         write_csr(CSR_ROW_COUNT, cfg[0]);
         write_csr(CSR_COLUMN_COUNT, cfg[1]);
         write_csr(CSR_GAP_OPEN, cfg[2]);
         write_csr(CSR_GAP_EXTEND, cfg[3]);
         write_csr(CSR_PAIR_BONUS, cfg[4]);
         @(negedge clock);
         csr_wr_en <= 1'b0;
         nr = (row_cnt == 0) ? 1 : row_cnt;
         nc = (col_cnt == 0) ? 1 : col_cnt;
         if (nc > MAX_LEN) nc = MAX_LEN;
         budget = requests_sent + 200;
         // whole matrices only, so counts change at a matrix boundary
         do begin
            for (n = 0; n < nr * nc; n++) begin
               if ($urandom_range(0, 9) == 0)
                  send_req(KIND_LOAD, 5'($urandom), rand_entry(), 3'd0, 3'd0, 1'b0, 1'b0);
               send_req(KIND_CELL, 5'($urandom), 16'($urandom),
                        ($urandom_range(0, 7) == 0) ? 3'($urandom) : 3'($urandom_range(0, 4)),
                        ($urandom_range(0, 7) == 0) ? 3'($urandom) : 3'($urandom_range(0, 4)),
                        1'($urandom), 1'($urandom));
            end
         end while (requests_sent < budget);
         p++;
      end
      drain();
      $display("%0d requests, %0d cells checked over %0d matrices in %0d phases",
               requests_sent, cells_seen, matrices, p);
      $display("%0d saturated cells; %0d mismatches", saturated, mismatches);
      if (mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

/* local_alignment_cell_fill.f */
design/lacf_pkg.sv
design/lacf_bank.sv
design/lacf_cell.sv
design/local_alignment_cell_fill.sv
verif/tb_local_alignment_cell_fill.sv
